FILE: rtl/qbpg_pkg.sv
// ============================================================================
// qbpg_pkg: shared types and constants for the quadratic Bezier point generator
// Coordinate, weight and accumulator widths, plus the control structs that
// pass between the sequencer, the multiply-accumulate unit and the divider.
// ============================================================================
package qbpg_pkg;

    localparam int COORD_W  = 16;   // width of one coordinate
    localparam int N_COORDS = 6;    // control point coordinates per request
    localparam int SEG_W    = 6;    // width of the segment count
    localparam int WGT_W    = 12;   // weights and N^2, at most 63*63
    localparam int OPA_W    = WGT_W + 1;          // signed multiplier operand A
    localparam int ACC_W    = 28;   // |numerator| <= 3969 * 32768 < 2^27
    localparam int DIV_CNT_W = $clog2(ACC_W);

    localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(16);

    // multiply-accumulate control: load starts a new sum, acc adds to it
    typedef struct packed {
        logic load;
        logic acc;
    } mac_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEN  = 6'b000010,
        S_WGT  = 6'b000100,
        S_MAC  = 6'b001000,
        S_DIV  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

endpackage

FILE: rtl/qbpg_mac.sv
// ============================================================================
// qbpg_mac: shared multiply-accumulate unit
// One signed 13x16 multiply per cycle into a registered accumulator; used for
// the weights, for N^2 and for the weighted coordinate sums.
// ============================================================================
module qbpg_mac (
    input  logic                                clk,
    input  qbpg_pkg::mac_ctl_t                  ctl,
    input  logic signed [qbpg_pkg::OPA_W-1:0]   op_a,
    input  logic signed [qbpg_pkg::COORD_W-1:0] op_b,
    output logic signed [qbpg_pkg::ACC_W-1:0]   acc
);

    localparam int PROD_W = qbpg_pkg::OPA_W + qbpg_pkg::COORD_W;

    logic signed [PROD_W-1:0]          prod;
    logic signed [qbpg_pkg::ACC_W-1:0] prod_trunc;
    logic signed [qbpg_pkg::ACC_W-1:0] acc_reg;
    logic signed [qbpg_pkg::ACC_W-1:0] acc_next;

    assign prod       = op_a * op_b;
    // every product used here fits the accumulator width
    assign prod_trunc = signed'(prod[qbpg_pkg::ACC_W-1:0]);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.load)
        begin
            acc_next = prod_trunc;
        end
        else if (ctl.acc)
        begin
            acc_next = acc_reg + prod_trunc;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

FILE: rtl/qbpg_div.sv
// ============================================================================
// qbpg_div: bit-serial signed divider
// Restoring division of a signed numerator by an unsigned N^2, one quotient
// bit per cycle; the quotient is truncated toward zero.
// ============================================================================
module qbpg_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [qbpg_pkg::ACC_W-1:0]   dividend,
    input  logic [qbpg_pkg::WGT_W-1:0]          divisor,
    output logic signed [qbpg_pkg::COORD_W-1:0] quotient,
    output qbpg_pkg::div_sts_t                  sts
);

    localparam logic [qbpg_pkg::DIV_CNT_W-1:0] LAST_BIT =
        qbpg_pkg::DIV_CNT_W'(qbpg_pkg::ACC_W - 1);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [qbpg_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [qbpg_pkg::ACC_W-1:0]        q_reg, q_next;
    logic [qbpg_pkg::WGT_W-1:0]        rem_reg, rem_next;
    logic [qbpg_pkg::WGT_W-1:0]        dvs_reg, dvs_next;
    logic                              neg_reg, neg_next;
    logic [qbpg_pkg::WGT_W:0]          trial;
    logic [qbpg_pkg::WGT_W:0]          rem_step;
    logic                              fits;
    logic [qbpg_pkg::ACC_W-1:0]        q_signed;

    assign trial    = {rem_reg, q_reg[qbpg_pkg::ACC_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_step = fits ? (trial - {1'b0, dvs_reg}) : trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[qbpg_pkg::ACC_W-1];
            q_next    = dividend[qbpg_pkg::ACC_W-1] ? unsigned'(-dividend)
                                                    : unsigned'(dividend);
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so its top bit drops out
            rem_next = rem_step[qbpg_pkg::WGT_W-1:0];
            q_next   = {q_reg[qbpg_pkg::ACC_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign q_signed = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign quotient = signed'(q_signed[qbpg_pkg::COORD_W-1:0]);
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

FILE: rtl/quadratic_bezier_point_generator_core.sv
// ============================================================================
// quadratic_bezier_point_generator_core: quadratic Bezier curve point stream
// Each point takes three weights, then per axis a multiply-accumulate and a
// bit-serial divide by N^2; a curve of N segments gives N+1 points, and the
// next point waits for a free output register. The divider, run once per
// axis, sets the point rate. One request at a time; tready is low until the
// last point is loaded. Reset clears the sequencer and sets segments to 16.
// ============================================================================
module quadratic_bezier_point_generator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,     // segments
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y (16 bits each)
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // point_x, point_y (16 bits each)
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast     // last_point
);

    localparam int CW = qbpg_pkg::COORD_W;
    localparam int WW = qbpg_pkg::WGT_W;
    localparam int SW = qbpg_pkg::SEG_W;

    qbpg_pkg::state_t state_reg, state_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             axis_reg, axis_next;
    logic [SW-1:0]    i_reg, i_next;
    logic [SW-1:0]    n_reg, n_next;
    logic [SW-1:0]    seg_reg;
    logic             m_valid_reg, m_valid_next;

    logic signed [CW-1:0] coord_reg [0:qbpg_pkg::N_COORDS-1];
    logic [WW-1:0]        d_reg, w0_reg, w1_reg, w2_reg;
    logic signed [CW-1:0] px_reg, py_reg;
    logic [2*CW-1:0]      m_data_reg;
    logic                 m_last_reg;

    logic [SW-1:0]                      r_val;
    logic                               in_xfer;
    logic                               out_load;
    logic                               div_start;
    logic                               is_last;
    qbpg_pkg::mac_ctl_t                 mac_ctl;
    logic signed [qbpg_pkg::OPA_W-1:0]  op_a;
    logic signed [CW-1:0]               op_b;
    logic signed [qbpg_pkg::ACC_W-1:0]  acc;
    logic signed [CW-1:0]               div_q;
    qbpg_pkg::div_sts_t                 div_sts;

    assign s_axis_tready = (state_reg == qbpg_pkg::S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign r_val         = n_reg - i_reg;
    assign is_last       = (i_reg == n_reg);
    assign out_load      = (state_reg == qbpg_pkg::S_EMIT) &&
                           (!m_valid_reg || m_axis_tready);
    assign div_start     = (state_reg == qbpg_pkg::S_MAC) && (cnt_reg == 2'd3);

    // operand selection for the shared multiply-accumulate unit
    always_comb
    begin
        mac_ctl = '0;
        op_a    = '0;
        op_b    = '0;
        case (state_reg)
            qbpg_pkg::S_DEN:
            begin
                op_a         = signed'(qbpg_pkg::OPA_W'(n_reg));
                op_b         = signed'(CW'(n_reg));
                mac_ctl.load = (cnt_reg == 2'd0);
            end
            qbpg_pkg::S_WGT:
            begin
                case (cnt_reg)
                    2'd0:
                    begin
                        op_a = signed'(qbpg_pkg::OPA_W'(r_val));
                        op_b = signed'(CW'(r_val));
                        mac_ctl.load = 1'b1;
                    end
                    2'd1:
                    begin
                        op_a = signed'(qbpg_pkg::OPA_W'(r_val));
                        op_b = signed'(CW'(i_reg));
                        mac_ctl.load = 1'b1;
                    end
                    2'd2:
                    begin
                        op_a = signed'(qbpg_pkg::OPA_W'(i_reg));
                        op_b = signed'(CW'(i_reg));
                        mac_ctl.load = 1'b1;
                    end
                    default:
                    begin
                        mac_ctl = '0;
                    end
                endcase
            end
            qbpg_pkg::S_MAC:
            begin
                case (cnt_reg)
                    2'd0:
                    begin
                        op_a = signed'({1'b0, w0_reg});
                        op_b = axis_reg ? coord_reg[1] : coord_reg[0];
                        mac_ctl.load = 1'b1;
                    end
                    2'd1:
                    begin
                        op_a = signed'({1'b0, w1_reg});
                        op_b = axis_reg ? coord_reg[3] : coord_reg[2];
                        mac_ctl.acc = 1'b1;
                    end
                    2'd2:
                    begin
                        op_a = signed'({1'b0, w2_reg});
                        op_b = axis_reg ? coord_reg[5] : coord_reg[4];
                        mac_ctl.acc = 1'b1;
                    end
                    default:
                    begin
                        mac_ctl = '0;
                    end
                endcase
            end
            default:
            begin
                mac_ctl = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        axis_next    = axis_reg;
        i_next       = i_reg;
        n_next       = n_reg;
        m_valid_next = m_valid_reg;
        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            qbpg_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    // zero segments behaves as one
                    n_next     = (seg_reg == '0) ? SW'(1) : seg_reg;
                    i_next     = '0;
                    cnt_next   = '0;
                    state_next = qbpg_pkg::S_DEN;
                end
            end
            qbpg_pkg::S_DEN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd1)
                begin
                    cnt_next   = '0;
                    state_next = qbpg_pkg::S_WGT;
                end
            end
            qbpg_pkg::S_WGT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd3)
                begin
                    axis_next  = 1'b0;
                    state_next = qbpg_pkg::S_MAC;
                end
            end
            qbpg_pkg::S_MAC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = qbpg_pkg::S_DIV;
                end
            end
            qbpg_pkg::S_DIV:
            begin
                if (div_sts.done)
                begin
                    cnt_next = '0;
                    if (!axis_reg)
                    begin
                        axis_next  = 1'b1;
                        state_next = qbpg_pkg::S_MAC;
                    end
                    else
                    begin
                        state_next = qbpg_pkg::S_EMIT;
                    end
                end
            end
            qbpg_pkg::S_EMIT:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    cnt_next     = '0;
                    if (is_last)
                    begin
                        i_next     = '0;
                        state_next = qbpg_pkg::S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = qbpg_pkg::S_WGT;
                    end
                end
            end
            default:
            begin
                state_next = qbpg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= qbpg_pkg::S_IDLE;
            cnt_reg     <= '0;
            axis_reg    <= 1'b0;
            i_reg       <= '0;
            n_reg       <= SW'(1);
            seg_reg     <= qbpg_pkg::SEG_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            axis_reg    <= axis_next;
            i_reg       <= i_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
            begin
                seg_reg <= cfg_wr_data;
            end
        end
    end

    // datapath holding registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            for (int k = 0; k < qbpg_pkg::N_COORDS; k++)
            begin
                coord_reg[k] <= signed'(s_axis_tdata[k*CW +: CW]);
            end
        end
        if (state_reg == qbpg_pkg::S_DEN && cnt_reg == 2'd1)
        begin
            d_reg <= acc[WW-1:0];
        end
        if (state_reg == qbpg_pkg::S_WGT)
        begin
            // the accumulator is registered, so it holds the product of the previous operands
            case (cnt_reg)
                2'd1:    w0_reg <= acc[WW-1:0];
                2'd2:    w1_reg <= {acc[WW-2:0], 1'b0};
                2'd3:    w2_reg <= acc[WW-1:0];
                default: w0_reg <= w0_reg;
            endcase
        end
        if (state_reg == qbpg_pkg::S_DIV && div_sts.done)
        begin
            if (axis_reg)
            begin
                py_reg <= div_q;
            end
            else
            begin
                px_reg <= div_q;
            end
        end
        if (out_load)
        begin
            m_data_reg <= {py_reg, px_reg};
            m_last_reg <= is_last;
        end
    end

    qbpg_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    qbpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc),
        .divisor  (d_reg),
        .quotient (div_q),
        .sts      (div_sts)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qbpg_pkg::S_IDLE) |-> !div_sts.busy)
        else $error("divider busy while sequencer idle");

    a_start_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider restarted while busy");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != qbpg_pkg::S_IDLE) |-> (i_reg <= n_reg))
        else $error("point index beyond segment count");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("final point not marked last");

endmodule
